// ----- hw/rtl/ssi_pkg.sv -----
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared widths, register indexes and the flag bundle for the segment/sphere
// intersection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ssi_pkg;

    localparam int INDEX_BITS   = 8;
    localparam int RADIUS_BITS  = 16;
    localparam int R2_BITS      = 2 * RADIUS_BITS;
    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CENTER_X,
        CFG_CENTER_Y,
        CFG_CENTER_Z,
        CFG_RADIUS
    } ssi_cfg_idx_t;

    // endpoint decisions made ahead of the wide compare
    typedef struct packed {
        logic start_case;   // t clamps to 0 (or zero-length segment)
        logic end_case;     // t clamps to 1
        logic start_hit;    // start point within radius
        logic end_hit;      // end point within radius
    } ssi_flags_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ssi_if.sv -----
// ----------------------------------------------------------------------------
// ssi_if
// Valid/ready channels: segment requests in, hit results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssi_seg_if import ssi_pkg::*; #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] start_z;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] end_z;
    logic [INDEX_BITS-1:0]        segment_index;

    modport source (
        output valid, start_x, start_y, start_z, end_x, end_y, end_z, segment_index,
        input  ready
    );

    modport sink (
        input  valid, start_x, start_y, start_z, end_x, end_y, end_z, segment_index,
        output ready
    );
endinterface

interface ssi_res_if import ssi_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] index_out;
    logic                  hit;

    modport source (
        output valid, index_out, hit,
        input  ready
    );

    modport sink (
        input  valid, index_out, hit,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/ssi_front.sv -----
// ----------------------------------------------------------------------------
// ssi_front
// Four-stage front end: coordinate differences, products, sums, then cross
// product magnitudes and the clamped-endpoint decisions.
// ----------------------------------------------------------------------------
`default_nettype none

module ssi_front import ssi_pkg::*; #(
    parameter int COORD_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    ssi_seg_if.sink                           seg,
    input  logic signed [COORD_BITS-1:0]      center_x,
    input  logic signed [COORD_BITS-1:0]      center_y,
    input  logic signed [COORD_BITS-1:0]      center_z,
    input  logic [RADIUS_BITS-1:0]            radius,
    output logic                              dn_valid,
    input  logic                              dn_ready,
    output logic [2:0][2*COORD_BITS:0]        cmag,
    output logic [2*COORD_BITS+1:0]           len2,
    output logic [R2_BITS-1:0]                r2,
    output ssi_flags_t                        flags,
    output logic [INDEX_BITS-1:0]             index
);

    localparam int N    = COORD_BITS;
    localparam int DW   = N + 1;
    localparam int PW   = 2 * DW;
    localparam int LW   = 2 * N + 2;
    localparam int CW   = 2 * N + 1;
    localparam int SW   = 2 * N + 4;
    localparam int EW   = (LW > R2_BITS) ? LW : R2_BITS;
    localparam int NSTG = 4;

    function automatic logic signed [PW-1:0] smul(
        input logic signed [DW-1:0] a,
        input logic signed [DW-1:0] b
    );
        smul = PW'(a) * PW'(b);
    endfunction

    // pipeline control
    logic [NSTG-1:0]                 v_reg;
    logic [NSTG-1:0]                 v_next;
    logic [NSTG-1:0]                 rdy;
    logic [NSTG-1:0][INDEX_BITS-1:0] idx_reg;
    logic [NSTG-1:0][INDEX_BITS-1:0] idx_next;

    always_comb
    begin
        rdy[NSTG-1] = !v_reg[NSTG-1] || dn_ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
        v_next   = {v_reg[NSTG-2:0], seg.valid};
        idx_next = {idx_reg[NSTG-2:0], seg.segment_index};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_next[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NSTG; k++)
        begin
            if (rdy[k])
            begin
                idx_reg[k] <= idx_next[k];
            end
        end
    end

    // r^2 follows the radius register
    logic [R2_BITS-1:0] r2_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r2_cfg_reg <= '0;
        end
        else
        begin
            r2_cfg_reg <= R2_BITS'(radius) * R2_BITS'(radius);
        end
    end

    // stage 1: d = e - s, w = c - s, ce = c - e
    logic signed [DW-1:0] s_ext [3];
    logic signed [DW-1:0] e_ext [3];
    logic signed [DW-1:0] c_ext [3];
    logic signed [DW-1:0] d_reg [3];
    logic signed [DW-1:0] d_next [3];
    logic signed [DW-1:0] w_reg [3];
    logic signed [DW-1:0] w_next [3];
    logic signed [DW-1:0] ce_reg [3];
    logic signed [DW-1:0] ce_next [3];

    always_comb
    begin
        s_ext[0] = {seg.start_x[N-1], seg.start_x};
        s_ext[1] = {seg.start_y[N-1], seg.start_y};
        s_ext[2] = {seg.start_z[N-1], seg.start_z};
        e_ext[0] = {seg.end_x[N-1], seg.end_x};
        e_ext[1] = {seg.end_y[N-1], seg.end_y};
        e_ext[2] = {seg.end_z[N-1], seg.end_z};
        c_ext[0] = {center_x[N-1], center_x};
        c_ext[1] = {center_y[N-1], center_y};
        c_ext[2] = {center_z[N-1], center_z};
        for (int i = 0; i < 3; i++)
        begin
            d_next[i]  = e_ext[i] - s_ext[i];
            w_next[i]  = c_ext[i] - s_ext[i];
            ce_next[i] = c_ext[i] - e_ext[i];
        end
    end

    // stage 2: products
    logic signed [PW-1:0] dotp_reg [3];
    logic signed [PW-1:0] dotp_next [3];
    logic signed [PW-1:0] dsq_reg [3];
    logic signed [PW-1:0] dsq_next [3];
    logic signed [PW-1:0] wsq_reg [3];
    logic signed [PW-1:0] wsq_next [3];
    logic signed [PW-1:0] cesq_reg [3];
    logic signed [PW-1:0] cesq_next [3];
    logic signed [PW-1:0] xp_reg [6];
    logic signed [PW-1:0] xp_next [6];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dotp_next[i] = smul(w_reg[i], d_reg[i]);
            dsq_next[i]  = smul(d_reg[i], d_reg[i]);
            wsq_next[i]  = smul(w_reg[i], w_reg[i]);
            cesq_next[i] = smul(ce_reg[i], ce_reg[i]);
        end
        xp_next[0] = smul(w_reg[1], d_reg[2]);
        xp_next[1] = smul(w_reg[2], d_reg[1]);
        xp_next[2] = smul(w_reg[2], d_reg[0]);
        xp_next[3] = smul(w_reg[0], d_reg[2]);
        xp_next[4] = smul(w_reg[0], d_reg[1]);
        xp_next[5] = smul(w_reg[1], d_reg[0]);
    end

    // stage 3: dot, |d|^2, |w|^2, |ce|^2, w x d
    logic signed [SW-1:0] dot_reg;
    logic signed [SW-1:0] dot_next;
    logic [LW-1:0]        len2_reg;
    logic [LW-1:0]        len2_next;
    logic [LW-1:0]        w2_reg;
    logic [LW-1:0]        w2_next;
    logic [LW-1:0]        ce2_reg;
    logic [LW-1:0]        ce2_next;
    logic signed [PW-1:0] cross_reg [3];
    logic signed [PW-1:0] cross_next [3];

    always_comb
    begin
        dot_next  = SW'(dotp_reg[0]) + SW'(dotp_reg[1]) + SW'(dotp_reg[2]);
        len2_next = $unsigned(dsq_reg[0]) + $unsigned(dsq_reg[1]) + $unsigned(dsq_reg[2]);
        w2_next   = $unsigned(wsq_reg[0]) + $unsigned(wsq_reg[1]) + $unsigned(wsq_reg[2]);
        ce2_next  = $unsigned(cesq_reg[0]) + $unsigned(cesq_reg[1])
                  + $unsigned(cesq_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            cross_next[i] = xp_reg[2*i] - xp_reg[2*i+1];
        end
    end

    // stage 4: cross magnitudes, clamp decisions
    logic signed [PW-1:0]  ncross [3];
    logic [2:0][CW-1:0]    cmag_reg;
    logic [2:0][CW-1:0]    cmag_next;
    logic [LW-1:0]         len2o_reg;
    ssi_flags_t            flags_reg;
    ssi_flags_t            flags_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ncross[i]    = -cross_reg[i];
            cmag_next[i] = cross_reg[i][PW-1] ? ncross[i][CW-1:0] : cross_reg[i][CW-1:0];
        end
        flags_next.start_case = (len2_reg == '0) || dot_reg[SW-1];
        flags_next.end_case   = dot_reg > $signed({{(SW-LW){1'b0}}, len2_reg});
        flags_next.start_hit  = EW'(w2_reg) <= EW'(r2_cfg_reg);
        flags_next.end_hit    = EW'(ce2_reg) <= EW'(r2_cfg_reg);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            d_reg  <= d_next;
            w_reg  <= w_next;
            ce_reg <= ce_next;
        end
        if (rdy[1])
        begin
            dotp_reg <= dotp_next;
            dsq_reg  <= dsq_next;
            wsq_reg  <= wsq_next;
            cesq_reg <= cesq_next;
            xp_reg   <= xp_next;
        end
        if (rdy[2])
        begin
            dot_reg   <= dot_next;
            len2_reg  <= len2_next;
            w2_reg    <= w2_next;
            ce2_reg   <= ce2_next;
            cross_reg <= cross_next;
        end
        if (rdy[3])
        begin
            cmag_reg  <= cmag_next;
            len2o_reg <= len2_reg;
            flags_reg <= flags_next;
        end
    end

    assign seg.ready = rdy[0];
    assign dn_valid  = v_reg[NSTG-1];
    assign cmag      = cmag_reg;
    assign len2      = len2o_reg;
    assign r2        = r2_cfg_reg;
    assign flags     = flags_reg;
    assign index     = idx_reg[NSTG-1];

endmodule

`default_nettype wire

// ----- hw/rtl/ssi_back.sv -----
// ----------------------------------------------------------------------------
// ssi_back
// Four-stage back end: |w x d|^2 against r^2 * |d|^2 from split partial
// products, then the final hit selection into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssi_back import ssi_pkg::*; #(
    parameter int COORD_BITS = 24
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       up_valid,
    output logic                       up_ready,
    input  logic [2:0][2*COORD_BITS:0] cmag,
    input  logic [2*COORD_BITS+1:0]    len2,
    input  logic [R2_BITS-1:0]         r2,
    input  ssi_flags_t                 flags,
    input  logic [INDEX_BITS-1:0]      index,
    ssi_res_if.source                  res
);

    localparam int N    = COORD_BITS;
    localparam int CW   = 2 * N + 1;
    localparam int L    = (CW + 1) / 2;
    localparam int H    = CW - L;
    localparam int LW   = 2 * N + 2;
    localparam int LL   = N + 1;
    localparam int LH   = LW - LL;
    localparam int QW   = 2 * CW;
    localparam int RW   = R2_BITS + LW;
    localparam int TW   = QW + 2;
    localparam int MW   = (TW > RW) ? TW : RW;
    localparam int NSTG = 4;

    // pipeline control
    logic [NSTG-1:0]                 v_reg;
    logic [NSTG-1:0]                 v_next;
    logic [NSTG-1:0]                 rdy;
    logic [NSTG-1:0][INDEX_BITS-1:0] idx_reg;
    logic [NSTG-1:0][INDEX_BITS-1:0] idx_next;
    ssi_flags_t [NSTG-2:0]           fl_reg;
    ssi_flags_t [NSTG-2:0]           fl_next;

    always_comb
    begin
        rdy[NSTG-1] = !v_reg[NSTG-1] || res.ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
        v_next   = {v_reg[NSTG-2:0], up_valid};
        idx_next = {idx_reg[NSTG-2:0], index};
        fl_next  = {fl_reg[NSTG-3:0], flags};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_next[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NSTG; k++)
        begin
            if (rdy[k])
            begin
                idx_reg[k] <= idx_next[k];
            end
        end
        for (int k = 0; k < NSTG - 1; k++)
        begin
            if (rdy[k])
            begin
                fl_reg[k] <= fl_next[k];
            end
        end
    end

    // stage 5: m = a*2^L + b, partial products; r^2 * len2 halves
    logic [H-1:0]            a_hi [3];
    logic [L-1:0]            b_lo [3];
    logic [2*H-1:0]          aa_reg [3];
    logic [2*H-1:0]          aa_next [3];
    logic [H+L-1:0]          ab_reg [3];
    logic [H+L-1:0]          ab_next [3];
    logic [2*L-1:0]          bb_reg [3];
    logic [2*L-1:0]          bb_next [3];
    logic [R2_BITS+LL-1:0]   rl_reg;
    logic [R2_BITS+LL-1:0]   rl_next;
    logic [R2_BITS+LH-1:0]   rh_reg;
    logic [R2_BITS+LH-1:0]   rh_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_hi[i]    = cmag[i][CW-1:L];
            b_lo[i]    = cmag[i][L-1:0];
            aa_next[i] = (2*H)'(a_hi[i]) * (2*H)'(a_hi[i]);
            ab_next[i] = (H+L)'(a_hi[i]) * (H+L)'(b_lo[i]);
            bb_next[i] = (2*L)'(b_lo[i]) * (2*L)'(b_lo[i]);
        end
        rl_next = (R2_BITS+LL)'(r2) * (R2_BITS+LL)'(len2[LL-1:0]);
        rh_next = (R2_BITS+LH)'(r2) * (R2_BITS+LH)'(len2[LW-1:LL]);
    end

    // stage 6: per-axis squares, rhs = r^2 * len2
    logic [QW-1:0] sq_reg [3];
    logic [QW-1:0] sq_next [3];
    logic [RW-1:0] rhs_reg;
    logic [RW-1:0] rhs_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i] = (QW'(aa_reg[i]) << (2*L)) + (QW'(ab_reg[i]) << (L+1))
                       + QW'(bb_reg[i]);
        end
        rhs_next = RW'(rl_reg) + (RW'(rh_reg) << LL);
    end

    // stage 7: |w x d|^2
    logic [TW-1:0] sum_reg;
    logic [TW-1:0] sum_next;
    logic [RW-1:0] rhs7_reg;

    always_comb
    begin
        sum_next = TW'(sq_reg[0]) + TW'(sq_reg[1]) + TW'(sq_reg[2]);
    end

    // stage 8: result
    logic inner_hit;
    logic hit_reg;
    logic hit_next;

    always_comb
    begin
        inner_hit = MW'(sum_reg) <= MW'(rhs7_reg);
        if (fl_reg[NSTG-2].start_case)
        begin
            hit_next = fl_reg[NSTG-2].start_hit;
        end
        else if (fl_reg[NSTG-2].end_case)
        begin
            hit_next = fl_reg[NSTG-2].end_hit;
        end
        else
        begin
            hit_next = inner_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            aa_reg <= aa_next;
            ab_reg <= ab_next;
            bb_reg <= bb_next;
            rl_reg <= rl_next;
            rh_reg <= rh_next;
        end
        if (rdy[1])
        begin
            sq_reg  <= sq_next;
            rhs_reg <= rhs_next;
        end
        if (rdy[2])
        begin
            sum_reg  <= sum_next;
            rhs7_reg <= rhs_reg;
        end
        if (rdy[3])
        begin
            hit_reg <= hit_next;
        end
    end

    assign up_ready      = rdy[0];
    assign res.valid     = v_reg[NSTG-1];
    assign res.hit       = hit_reg;
    assign res.index_out = idx_reg[NSTG-1];

endmodule

`default_nettype wire

// ----- hw/rtl/segment_sphere_intersect_top.sv -----
// ----------------------------------------------------------------------------
// segment_sphere_intersect_top
// Pipeline: eight register stages of the multiply/sum/compare datapath, the last
//   one the result register.
// Throughput: one segment per cycle unless stalled; each stage stalls only when full and
//   blocked downstream, so bubbles are squeezed out under backpressure.
// Reset: valid bits cleared, center and radius registers cleared to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_sphere_intersect_top import ssi_pkg::*; #(
    parameter int COORD_BITS = 24
) (
    input  logic                    clk,
    input  logic                    rst_n,
    ssi_seg_if.sink                 seg,
    ssi_res_if.source               res,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS)-1:0] cfg_data
);

    logic signed [COORD_BITS-1:0] center_x_reg;
    logic signed [COORD_BITS-1:0] center_y_reg;
    logic signed [COORD_BITS-1:0] center_z_reg;
    logic [RADIUS_BITS-1:0]       radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            radius_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (ssi_cfg_idx_t'(cfg_index))
                CFG_CENTER_X: center_x_reg <= cfg_data[COORD_BITS-1:0];
                CFG_CENTER_Y: center_y_reg <= cfg_data[COORD_BITS-1:0];
                CFG_CENTER_Z: center_z_reg <= cfg_data[COORD_BITS-1:0];
                CFG_RADIUS:   radius_reg   <= cfg_data[RADIUS_BITS-1:0];
                default:      ;
            endcase
        end
    end

    logic                        mid_valid;
    logic                        mid_ready;
    logic [2:0][2*COORD_BITS:0]  mid_cmag;
    logic [2*COORD_BITS+1:0]     mid_len2;
    logic [R2_BITS-1:0]          mid_r2;
    ssi_flags_t                  mid_flags;
    logic [INDEX_BITS-1:0]       mid_index;

    ssi_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .seg      (seg),
        .center_x (center_x_reg),
        .center_y (center_y_reg),
        .center_z (center_z_reg),
        .radius   (radius_reg),
        .dn_valid (mid_valid),
        .dn_ready (mid_ready),
        .cmag     (mid_cmag),
        .len2     (mid_len2),
        .r2       (mid_r2),
        .flags    (mid_flags),
        .index    (mid_index)
    );

    ssi_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (mid_valid),
        .up_ready (mid_ready),
        .cmag     (mid_cmag),
        .len2     (mid_len2),
        .r2       (mid_r2),
        .flags    (mid_flags),
        .index    (mid_index),
        .res      (res)
    );

    // a free output means every stage can move
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        res.ready |-> seg.ready)
        else $error("request side stalled while result side is ready");

    // t cannot clamp to both ends
    a_clamp_excl: assert property (@(posedge clk) disable iff (!rst_n)
        mid_valid |-> !(mid_flags.start_case && mid_flags.end_case))
        else $error("start and end clamp both set");

    // a point segment has no cross product
    a_point_cross: assert property (@(posedge clk) disable iff (!rst_n)
        (mid_valid && (mid_len2 == '0)) |-> (mid_cmag == '0))
        else $error("nonzero cross product for zero-length segment");

endmodule

`default_nettype wire
